// ===== src/tmp_pkg.sv =====
// Shared constants, codes and types of the trapezoid motion profile unit.
package tmp_pkg;

  localparam int unsigned ANGLE_FRAC_BITS_DEF = 24;
  localparam int unsigned TIME_FRAC_BITS_DEF  = 20;
  localparam int unsigned ACCEL_FRAC_BITS     = 16;

  localparam logic [31:0] ACCEL_RESET    = 32'd6553600;
  localparam logic [31:0] DURATION_RESET = 32'd1048576;

  // cycles the derived configuration products need to settle after a write
  localparam logic [1:0] CFG_SETTLE = 2'd3;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [0:0] {
    REG_ACCEL,
    REG_DURATION
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SEG_NONE,
    SEG_ACCEL,
    SEG_CRUISE,
    SEG_DECEL,
    SEG_ARRIVED
  } segment_e;

  typedef enum logic [1:0] {
    VEL_FOUND,
    VEL_UNREACHABLE,
    VEL_NO_ROOT
  } vel_status_e;

  // configuration registers and the products derived from them
  typedef struct packed {
    logic [31:0]  accel;
    logic [31:0]  duration;
    logic [63:0]  at;
    logic [95:0]  att;
    logic [127:0] at2;
  } cfg_vals_t;

  // classified item handed from the front end to the back end
  typedef struct packed {
    logic signed [31:0] start;
    logic               neg;
    logic [32:0]        dist_s;
    logic [31:0]        t;
    logic [31:0]        r;
    logic               t_lt;
    logic               t2_ge;
    logic [32:0]        cru_y;
    logic [31:0]        u;
    segment_e           tri_seg;
    logic               unreach;
    logic [63:0]        at;
    logic [63:0]        ar;
    logic [64:0]        as;
  } job_t;

endpackage

// ===== src/tmp_cfg.sv =====
// Configuration registers and the settled products of acceleration and duration.
module tmp_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  output tmp_pkg::cfg_vals_t  cfg_o,
  output logic                busy_o
);

  logic [31:0]  accel_q;
  logic [31:0]  dur_q;
  logic [1:0]   settle_q;
  logic [63:0]  at_q;
  logic [63:0]  att_lo_q;
  logic [63:0]  att_hi_q;
  logic [63:0]  sq_ll_q;
  logic [63:0]  sq_lh_q;
  logic [63:0]  sq_hh_q;
  logic [95:0]  att_q;
  logic [127:0] at2_q;

  // write registers, restart the settle count on every write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q  <= tmp_pkg::ACCEL_RESET;
      dur_q    <= tmp_pkg::DURATION_RESET;
      settle_q <= tmp_pkg::CFG_SETTLE;
    end else if (cfg_we_i) begin
      case (tmp_pkg::cfg_reg_e'(cfg_idx_i))
        tmp_pkg::REG_ACCEL:    accel_q <= cfg_data_i;
        tmp_pkg::REG_DURATION: dur_q   <= cfg_data_i;
        default: ;
      endcase
      settle_q <= tmp_pkg::CFG_SETTLE;
    end else if (settle_q != 2'd0) begin
      settle_q <= settle_q - 2'd1;
    end
  end

  // derive a*T, a*T*T and (a*T)^2 in three steps from 32-bit partial products
  always_ff @(posedge clk_i) begin
    at_q     <= {32'd0, accel_q} * {32'd0, dur_q};
    att_lo_q <= {32'd0, at_q[31:0]} * {32'd0, dur_q};
    att_hi_q <= {32'd0, at_q[63:32]} * {32'd0, dur_q};
    sq_ll_q  <= {32'd0, at_q[31:0]} * {32'd0, at_q[31:0]};
    sq_lh_q  <= {32'd0, at_q[31:0]} * {32'd0, at_q[63:32]};
    sq_hh_q  <= {32'd0, at_q[63:32]} * {32'd0, at_q[63:32]};
    att_q    <= 96'(att_lo_q) + (96'(att_hi_q) << 32);
    at2_q    <= 128'(sq_ll_q) + (128'(sq_lh_q) << 33) + (128'(sq_hh_q) << 64);
  end

  assign cfg_o.accel    = accel_q;
  assign cfg_o.duration = dur_q;
  assign cfg_o.at       = at_q;
  assign cfg_o.att      = att_q;
  assign cfg_o.at2      = at2_q;
  assign busy_o         = (settle_q != 2'd0);

endmodule

// ===== src/tmp_front.sv =====
// Front end: accept items, work out distance, time terms and reachability.
module tmp_front #(
  parameter int unsigned ScaleShift = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmp_pkg::cfg_vals_t  cfg_i,
  input  logic                busy_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  start_angle_i,
  input  logic signed [31:0]  target_angle_i,
  input  logic [31:0]         elapsed_time_i,
  output logic                push_o,
  output tmp_pkg::job_t       job_o,
  input  logic                full_i
);

  logic                adv;
  logic                f1_v_q;
  logic                f2_v_q;
  tmp_pkg::job_t       f1_d;
  tmp_pkg::job_t       f1_q;
  tmp_pkg::job_t       f2_d;
  tmp_pkg::job_t       f2_q;
  logic signed [32:0]  diff;
  logic [32:0]         t2;
  logic [32:0]         dur33;
  logic [127:0]        four_s;

  assign adv        = !f2_v_q || !full_i;
  assign in_ready_o = adv && !busy_i;

  // classify the item against the move duration
  always_comb begin
    diff         = 33'(target_angle_i) - 33'(start_angle_i);
    t2           = {elapsed_time_i, 1'b0};
    dur33        = {1'b0, cfg_i.duration};
    f1_d         = '0;
    f1_d.start   = start_angle_i;
    f1_d.neg     = diff[32];
    f1_d.dist_s  = diff[32] ? (~diff + 33'd1) : diff;
    f1_d.t       = elapsed_time_i;
    f1_d.r       = cfg_i.duration - elapsed_time_i;
    f1_d.t_lt    = elapsed_time_i < cfg_i.duration;
    f1_d.t2_ge   = t2 >= dur33;
    f1_d.cru_y   = f1_d.t2_ge ? (t2 - dur33) : (dur33 - t2);
    f1_d.u       = f1_d.t2_ge ? f1_d.r : elapsed_time_i;
    if (!f1_d.t2_ge) begin
      f1_d.tri_seg = tmp_pkg::SEG_ACCEL;
    end else if (f1_d.t_lt) begin
      f1_d.tri_seg = tmp_pkg::SEG_DECEL;
    end else begin
      f1_d.tri_seg = tmp_pkg::SEG_ARRIVED;
    end
  end

  // form the acceleration products and test reachability
  always_comb begin
    four_s       = 128'({f1_q.dist_s, 2'b00}) << ScaleShift;
    f2_d         = f1_q;
    f2_d.at      = {32'd0, cfg_i.accel} * {32'd0, f1_q.t};
    f2_d.ar      = {32'd0, cfg_i.accel} * {32'd0, f1_q.r};
    f2_d.as      = {33'd0, cfg_i.accel} * {32'd0, f1_q.dist_s};
    f2_d.unreach = four_s > 128'(cfg_i.att);
  end

  // advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else if (adv) begin
      f1_v_q <= in_valid_i && in_ready_o;
      f2_v_q <= f1_v_q;
    end
  end

  // advance payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_q <= f1_d;
      f2_q <= f2_d;
    end
  end

  assign push_o = f2_v_q;
  assign job_o  = f2_q;

endmodule

// ===== src/tmp_queue.sv =====
// Short queue of classified items between the front and back ends.
module tmp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tmp_pkg::job_t  data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tmp_pkg::job_t  data_o
);

  localparam int unsigned Depth = tmp_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tmp_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  // move pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // store the item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/tmp_back.sv =====
// Back end: root and triangle divide pipelines, segment choice, distance and position.
module tmp_back #(
  parameter int unsigned ScaleShift = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmp_pkg::cfg_vals_t  cfg_i,
  input  logic                job_valid_i,
  input  tmp_pkg::job_t       job_i,
  output logic                job_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  position_o,
  output logic [2:0]          segment_o,
  output logic                triangle_used_o,
  output logic [1:0]          velocity_status_o
);

  localparam int unsigned RootBits = 64;

  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_ACC,
    MODE_CRU_ADD,
    MODE_CRU_SUB,
    MODE_DEC,
    MODE_TRI_ACC,
    MODE_TRI_DEC,
    MODE_ARRIVED
  } mode_e;

  typedef struct packed {
    logic signed [31:0]  start;
    logic                neg;
    logic [32:0]         s;
    logic [31:0]         t;
    logic [31:0]         r;
    logic                t_lt;
    logic                t2_ge;
    logic [32:0]         cru_y;
    tmp_pkg::segment_e   tri_seg;
    logic                unreach;
    logic [63:0]         at;
    logic [63:0]         ar;
  } carry_t;

  typedef struct packed {
    carry_t       c;
    logic [128:0] rem;
    logic [63:0]  root;
    logic [31:0]  drem;
    logic [31:0]  dq;
    logic [63:0]  qq;
  } sq_t;

  typedef struct packed {
    logic signed [31:0]     start;
    logic                   neg;
    logic [32:0]            s;
    mode_e                  mode;
    tmp_pkg::segment_e      seg;
    logic                   tri_used;
    tmp_pkg::vel_status_e   status;
  } post_t;

  logic                 adv;
  sq_t                  sq_d [RootBits+1];
  sq_t                  sq_q [RootBits+1];
  logic [RootBits:0]    sq_v_q;
  logic [5:0]           m_v_q;

  post_t                m1_d, m1_q, m2_q, m3_q, m4_q, m5_q;
  logic [63:0]          x_d, x_q;
  logic [33:0]          y_d, y_q;
  logic [65:0]          plo_q, phi_q;
  logic [99:0]          prod_q;
  logic [99:0]          sh_d, sh_q;
  logic [99:0]          base;
  logic [32:0]          clamped;
  logic [32:0]          dist_d, dist_q;
  logic [63:0]          vel;
  logic signed [31:0]   pos_d, pos_q;
  post_t                out_q;

  assign adv       = !out_valid_o || out_ready_i;
  assign job_pop_o = adv && job_valid_i;

  // load the radicand and the divide remainder
  always_comb begin
    sq_d[0]           = '0;
    sq_d[0].c.start   = job_i.start;
    sq_d[0].c.neg     = job_i.neg;
    sq_d[0].c.s       = job_i.dist_s;
    sq_d[0].c.t       = job_i.t;
    sq_d[0].c.r       = job_i.r;
    sq_d[0].c.t_lt    = job_i.t_lt;
    sq_d[0].c.t2_ge   = job_i.t2_ge;
    sq_d[0].c.cru_y   = job_i.cru_y;
    sq_d[0].c.tri_seg = job_i.tri_seg;
    sq_d[0].c.unreach = job_i.unreach;
    sq_d[0].c.at      = job_i.at;
    sq_d[0].c.ar      = job_i.ar;
    sq_d[0].rem       = 129'(cfg_i.at2 - (128'(job_i.as) << (ScaleShift + 2)));
    sq_d[0].drem      = job_i.u;
  end

  // one root bit per stage; one quotient bit per stage in the first 32
  for (genvar k = 0; k < RootBits; k++) begin : g_root
    localparam int unsigned Bit = RootBits - 1 - k;
    logic [128:0] trial;
    logic [32:0]  dsh;
    always_comb begin
      sq_d[k+1] = sq_q[k];
      trial     = (129'(sq_q[k].root) << (Bit + 1)) | (129'(1) << (2 * Bit));
      dsh       = {sq_q[k].drem, 1'b0};
      if (sq_q[k].rem >= trial) begin
        sq_d[k+1].rem  = sq_q[k].rem - trial;
        sq_d[k+1].root = sq_q[k].root | (64'(1) << Bit);
      end
      if (k < 32) begin
        if (dsh >= {1'b0, cfg_i.duration}) begin
          sq_d[k+1].drem = 32'(dsh - {1'b0, cfg_i.duration});
          sq_d[k+1].dq   = {sq_q[k].dq[30:0], 1'b1};
        end else begin
          sq_d[k+1].drem = dsh[31:0];
          sq_d[k+1].dq   = {sq_q[k].dq[30:0], 1'b0};
        end
      end
      if (k == 32) begin
        sq_d[k+1].qq = {32'd0, sq_q[k].dq} * {32'd0, sq_q[k].dq};
      end
    end
  end

  // pick the segment and the operands of the distance product
  always_comb begin
    sq_t p;
    p              = sq_q[RootBits];
    vel            = (cfg_i.at - p.root) >> 1;
    m1_d.start     = p.c.start;
    m1_d.neg       = p.c.neg;
    m1_d.s         = p.c.s;
    m1_d.tri_used  = 1'b0;
    if (p.c.unreach) begin
      m1_d.status = tmp_pkg::VEL_UNREACHABLE;
    end else if (p.c.s != 33'd0 && vel == 64'd0) begin
      m1_d.status = tmp_pkg::VEL_NO_ROOT;
    end else begin
      m1_d.status = tmp_pkg::VEL_FOUND;
    end
    x_d = '0;
    y_d = '0;
    if (p.c.s == 33'd0) begin
      m1_d.mode = MODE_NONE;
      m1_d.seg  = tmp_pkg::SEG_NONE;
    end else if (m1_d.status != tmp_pkg::VEL_FOUND) begin
      m1_d.tri_used = 1'b1;
      m1_d.seg      = p.c.tri_seg;
      x_d           = p.qq;
      y_d           = {p.c.s, 1'b0};
      case (p.c.tri_seg)
        tmp_pkg::SEG_ACCEL: m1_d.mode = MODE_TRI_ACC;
        tmp_pkg::SEG_DECEL: m1_d.mode = MODE_TRI_DEC;
        default:            m1_d.mode = MODE_ARRIVED;
      endcase
    end else if (p.c.at < vel) begin
      m1_d.mode = MODE_ACC;
      m1_d.seg  = tmp_pkg::SEG_ACCEL;
      x_d       = p.c.at;
      y_d       = 34'(p.c.t);
    end else if (p.c.t_lt && p.c.ar > vel) begin
      m1_d.mode = p.c.t2_ge ? MODE_CRU_ADD : MODE_CRU_SUB;
      m1_d.seg  = tmp_pkg::SEG_CRUISE;
      x_d       = vel;
      y_d       = 34'(p.c.cru_y);
    end else if (p.c.t_lt) begin
      m1_d.mode = MODE_DEC;
      m1_d.seg  = tmp_pkg::SEG_DECEL;
      x_d       = p.c.ar;
      y_d       = 34'(p.c.r);
    end else begin
      m1_d.mode = MODE_ARRIVED;
      m1_d.seg  = tmp_pkg::SEG_ARRIVED;
    end
  end

  // scale the product down by the segment's rule
  always_comb begin
    base = 100'(m3_q.s) << ScaleShift;
    case (m3_q.mode)
      MODE_ACC, MODE_DEC:         sh_d = prod_q >> (ScaleShift + 1);
      MODE_CRU_ADD:               sh_d = (base + prod_q) >> (ScaleShift + 1);
      MODE_CRU_SUB:               sh_d = (prod_q > base) ? '0
                                         : (base - prod_q) >> (ScaleShift + 1);
      MODE_TRI_ACC, MODE_TRI_DEC: sh_d = prod_q >> 64;
      default:                    sh_d = '0;
    endcase
  end

  // clamp to the move length and fold decelerating segments
  always_comb begin
    clamped = (sh_q > 100'(m4_q.s)) ? m4_q.s : sh_q[32:0];
    case (m4_q.mode)
      MODE_DEC, MODE_TRI_DEC: dist_d = m4_q.s - clamped;
      MODE_ARRIVED:           dist_d = m4_q.s;
      MODE_NONE:              dist_d = '0;
      default:                dist_d = clamped;
    endcase
  end

  assign pos_d = m5_q.neg ? (m5_q.start - signed'(dist_q[31:0]))
                          : (m5_q.start + signed'(dist_q[31:0]));

  // advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= '0;
      m_v_q  <= '0;
    end else if (adv) begin
      sq_v_q <= {sq_v_q[RootBits-1:0], job_pop_o};
      m_v_q  <= {m_v_q[4:0], sq_v_q[RootBits]};
    end
  end

  // advance payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= RootBits; k++) begin
        sq_q[k] <= sq_d[k];
      end
      m1_q   <= m1_d;
      x_q    <= x_d;
      y_q    <= y_d;
      m2_q   <= m1_q;
      plo_q  <= 66'(x_q[31:0]) * 66'(y_q);
      phi_q  <= 66'(x_q[63:32]) * 66'(y_q);
      m3_q   <= m2_q;
      prod_q <= 100'(plo_q) + (100'(phi_q) << 32);
      m4_q   <= m3_q;
      sh_q   <= sh_d;
      m5_q   <= m4_q;
      dist_q <= dist_d;
      out_q  <= m5_q;
      pos_q  <= pos_d;
    end
  end

  assign out_valid_o       = m_v_q[5];
  assign position_o        = pos_q;
  assign segment_o         = out_q.seg;
  assign triangle_used_o   = out_q.tri_used;
  assign velocity_status_o = out_q.status;

endmodule

// ===== src/trapezoid_motion_profile_unit.sv =====
// Trapezoid motion profile unit: top level tying configuration, front end, queue and back end.
// Each item (start angle, target angle, elapsed time) gives one sample of a trapezoidal
// velocity profile planned for the configured acceleration and move duration, falling
// back to a triangle profile when the move is unreachable or the peak velocity has no
// usable root. One item is taken per clock cycle unless the input is held off by a
// configuration write or by back-pressure from the output and queue; an item's result
// passes two front stages, the queue hop, 65 square-root stages (a load stage and one
// per root bit) and six stages of segment choice, multiply and position. After any
// configuration write the input is held off while the derived acceleration products settle.
module trapezoid_motion_profile_unit #(
  parameter int unsigned ANGLE_FRAC_BITS = tmp_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int unsigned TIME_FRAC_BITS  = tmp_pkg::TIME_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] start_angle_i,
  input  logic signed [31:0] target_angle_i,
  input  logic [31:0]        elapsed_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] position_o,
  output logic [2:0]         segment_o,
  output logic               triangle_used_o,
  output logic [1:0]         velocity_status_o
);

  localparam int unsigned ScaleShift =
    tmp_pkg::ACCEL_FRAC_BITS + 2 * TIME_FRAC_BITS - ANGLE_FRAC_BITS;

  tmp_pkg::cfg_vals_t cfg;
  logic               busy;
  logic               push;
  logic               full;
  logic               pop;
  logic               job_valid;
  tmp_pkg::job_t      job_in;
  tmp_pkg::job_t      job_out;

  tmp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .busy_o     (busy)
  );

  tmp_front #(
    .ScaleShift (ScaleShift)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .busy_i         (busy),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .start_angle_i  (start_angle_i),
    .target_angle_i (target_angle_i),
    .elapsed_time_i (elapsed_time_i),
    .push_o         (push),
    .job_o          (job_in),
    .full_i         (full)
  );

  tmp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .data_o  (job_out)
  );

  tmp_back #(
    .ScaleShift (ScaleShift)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .job_valid_i       (job_valid),
    .job_i             (job_out),
    .job_pop_o         (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .position_o        (position_o),
    .segment_o         (segment_o),
    .triangle_used_o   (triangle_used_o),
    .velocity_status_o (velocity_status_o)
  );

endmodule
